### rtl/core/kmp_pkg.sv
// ----------------------------------------------------------------------------
// kmp_pkg
// Shared types, constants and helpers for the stream pattern search unit.
// ----------------------------------------------------------------------------
package kmp_pkg;

    localparam int MAX_PATTERN_DEF = 32;
    localparam int OP_W            = 2;
    localparam int BYTE_W          = 8;
    localparam int POS_W           = 32;
    localparam int LEN_W           = 6;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int PAT_WORDS       = 4;
    localparam int PAT_IDX_W       = 5;

    typedef enum logic [OP_W-1:0] {
        OP_BUILD   = 2'd0,
        OP_RESTART = 2'd1,
        OP_DATA    = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LEN  = 3'd0,
        REG_PATTERN_W0   = 3'd1,
        REG_PATTERN_W1   = 3'd2,
        REG_PATTERN_W2   = 3'd3,
        REG_PATTERN_W3   = 3'd4,
        REG_BASE_OFFSET  = 3'd5,
        REG_SEARCH_LIMIT = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [LEN_W-1:0]                       pattern_len;
        logic [PAT_WORDS-1:0][CFG_DATA_W-1:0]   pattern_word;
        logic [POS_W-1:0]                       base_offset;
        logic [POS_W-1:0]                       search_limit;
    } cfg_t;

    function automatic logic [BYTE_W-1:0] cfg_byte(
        input logic [PAT_WORDS-1:0][CFG_DATA_W-1:0] words,
        input logic [PAT_IDX_W-1:0]                 k
    );
        logic [CFG_DATA_W-1:0] w;
        w = words[k[PAT_IDX_W-1:3]];
        return w[{k[2:0], 3'b000} +: BYTE_W];
    endfunction

endpackage

### rtl/core/kmp_cfg_regs.sv
// ----------------------------------------------------------------------------
// kmp_cfg_regs
// Configuration register file: pattern, length, base offset, search limit.
// ----------------------------------------------------------------------------
module kmp_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [kmp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [kmp_pkg::CFG_DATA_W-1:0]    cfg_data,
    output kmp_pkg::cfg_t                     cfg_out
);

    kmp_pkg::cfg_t cfg_reg;

    assign cfg_ready = aresetn;
    assign cfg_out   = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pattern_len  <= kmp_pkg::LEN_W'(1);
            cfg_reg.pattern_word <= '0;
            cfg_reg.base_offset  <= '0;
            cfg_reg.search_limit <= '1;
        end else if (cfg_valid) begin
            case (cfg_index)
                kmp_pkg::REG_PATTERN_LEN: begin
                    cfg_reg.pattern_len <= cfg_data[kmp_pkg::LEN_W-1:0];
                end
                kmp_pkg::REG_PATTERN_W0: begin
                    cfg_reg.pattern_word[0] <= cfg_data;
                end
                kmp_pkg::REG_PATTERN_W1: begin
                    cfg_reg.pattern_word[1] <= cfg_data;
                end
                kmp_pkg::REG_PATTERN_W2: begin
                    cfg_reg.pattern_word[2] <= cfg_data;
                end
                kmp_pkg::REG_PATTERN_W3: begin
                    cfg_reg.pattern_word[3] <= cfg_data;
                end
                kmp_pkg::REG_BASE_OFFSET: begin
                    cfg_reg.base_offset <= cfg_data[kmp_pkg::POS_W-1:0];
                end
                kmp_pkg::REG_SEARCH_LIMIT: begin
                    cfg_reg.search_limit <= cfg_data[kmp_pkg::POS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

### rtl/core/kmp_engine.sv
// ----------------------------------------------------------------------------
// kmp_engine
// Table build and byte search sequencer around the pattern and failure memories.
// ----------------------------------------------------------------------------
module kmp_engine #(
    parameter int MAX_PATTERN = kmp_pkg::MAX_PATTERN_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  kmp_pkg::cfg_t                  cfg,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [kmp_pkg::OP_W-1:0]       s_op,
    input  logic [kmp_pkg::BYTE_W-1:0]     s_data_byte,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [kmp_pkg::POS_W-1:0]      m_match_position
);

    localparam int DEPTH = MAX_PATTERN + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int VW    = AW + 1;
    localparam logic signed [VW-1:0] NEG_ONE = '1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_COPY,
        S_BRD,
        S_BCMP,
        S_BLINK,
        S_BCMP2,
        S_BFT,
        S_SCMP,
        S_OUT
    } state_t;

    state_t                        state_reg, state_next;
    logic [AW-1:0]                 len_reg, len_next;
    logic [AW-1:0]                 k_reg, k_next;
    logic signed [VW-1:0]          i_reg, i_next;
    logic signed [VW-1:0]          j_reg, j_next;
    logic signed [VW-1:0]          matched_reg, matched_next;
    logic signed [VW-1:0]          fail_end_reg, fail_end_next;
    logic                          ready_reg, ready_next;
    logic [kmp_pkg::BYTE_W-1:0]    c_reg, c_next;
    logic [kmp_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic [kmp_pkg::POS_W-1:0]     pend_reg, pend_next;
    logic                          m_valid_reg, m_valid_next;
    logic [kmp_pkg::POS_W-1:0]     m_data_reg, m_data_next;

    logic [kmp_pkg::BYTE_W-1:0]    pat_mem [DEPTH];
    logic signed [VW-1:0]          ft_mem  [DEPTH];

    logic                          pat_we;
    logic [AW-1:0]                 pat_waddr, pat_raddr_a, pat_raddr_b;
    logic [kmp_pkg::BYTE_W-1:0]    pat_wdata, pat_qa, pat_qb;
    logic                          ft_we;
    logic [AW-1:0]                 ft_waddr, ft_raddr;
    logic signed [VW-1:0]          ft_wdata, ft_q;

    logic signed [VW-1:0]          len_s;
    logic signed [VW-1:0]          i_inc, j_inc, ni;
    logic [AW-1:0]                 clamp_len;
    logic                          finish;

    assign len_s = $signed({1'b0, len_reg});
    assign i_inc = i_reg + VW'(1);
    assign j_inc = j_reg + VW'(1);

    always_comb begin
        if (cfg.pattern_len == '0) begin
            clamp_len = AW'(1);
        end else if (cfg.pattern_len > kmp_pkg::LEN_W'(MAX_PATTERN)) begin
            clamp_len = AW'(MAX_PATTERN);
        end else begin
            clamp_len = AW'(cfg.pattern_len);
        end
    end

    assign s_ready          = aresetn && (state_reg == S_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_match_position = m_data_reg;

    always_comb begin
        state_next    = state_reg;
        len_next      = len_reg;
        k_next        = k_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        matched_next  = matched_reg;
        fail_end_next = fail_end_reg;
        ready_next    = ready_reg;
        c_next        = c_reg;
        pos_next      = pos_reg;
        pend_next     = pend_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        pat_we        = 1'b0;
        pat_waddr     = k_reg;
        pat_wdata     = kmp_pkg::cfg_byte(cfg.pattern_word, kmp_pkg::PAT_IDX_W'(k_reg));
        pat_raddr_a   = i_reg[AW-1:0];
        pat_raddr_b   = j_reg[AW-1:0];
        ft_we         = 1'b0;
        ft_waddr      = i_reg[AW-1:0];
        ft_wdata      = j_reg;
        ft_raddr      = j_reg[AW-1:0];
        ni            = i_inc;
        finish        = 1'b0;

        case (state_reg)
            S_IDLE: begin
                pat_raddr_a = matched_reg[AW-1:0];
                ft_raddr    = matched_reg[AW-1:0];
                if (s_valid) begin
                    case (s_op)
                        kmp_pkg::OP_BUILD: begin
                            len_next     = clamp_len;
                            k_next       = '0;
                            ready_next   = 1'b0;
                            matched_next = '0;
                            pos_next     = '0;
                            state_next   = S_COPY;
                        end
                        kmp_pkg::OP_RESTART: begin
                            matched_next = '0;
                            pos_next     = '0;
                        end
                        kmp_pkg::OP_DATA: begin
                            if (ready_reg && (pos_reg < cfg.search_limit)) begin
                                c_next     = s_data_byte;
                                i_next     = matched_reg;
                                state_next = S_SCMP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_COPY: begin
                pat_we   = 1'b1;
                ft_we    = 1'b1;
                ft_waddr = '0;
                ft_wdata = NEG_ONE;
                k_next   = k_reg + AW'(1);
                if (k_reg == len_reg - AW'(1)) begin
                    i_next     = '0;
                    j_next     = NEG_ONE;
                    state_next = S_BRD;
                end
            end
            S_BRD: begin
                state_next = S_BCMP;
            end
            S_BCMP: begin
                if (!j_reg[VW-1] && (pat_qa != pat_qb)) begin
                    state_next = S_BLINK;
                end else begin
                    i_next = i_inc;
                    j_next = j_inc;
                    if (i_inc < len_s) begin
                        pat_raddr_a = i_inc[AW-1:0];
                        pat_raddr_b = j_inc[AW-1:0];
                        state_next  = S_BCMP2;
                    end else begin
                        ft_we         = 1'b1;
                        ft_waddr      = i_inc[AW-1:0];
                        ft_wdata      = j_inc;
                        fail_end_next = j_inc;
                        ready_next    = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
            end
            S_BLINK: begin
                j_next     = ft_q;
                state_next = S_BRD;
            end
            S_BCMP2: begin
                if (pat_qa == pat_qb) begin
                    state_next = S_BFT;
                end else begin
                    ft_we      = 1'b1;
                    state_next = S_BRD;
                end
            end
            S_BFT: begin
                ft_we      = 1'b1;
                ft_wdata   = ft_q;
                state_next = S_BRD;
            end
            S_SCMP: begin
                if (pat_qa != c_reg) begin
                    if (ft_q[VW-1]) begin
                        ni     = '0;
                        finish = 1'b1;
                    end else begin
                        i_next      = ft_q;
                        pat_raddr_a = ft_q[AW-1:0];
                        ft_raddr    = ft_q[AW-1:0];
                    end
                end else begin
                    ni     = i_inc;
                    finish = 1'b1;
                end
                if (finish) begin
                    pos_next = pos_reg + kmp_pkg::POS_W'(1);
                    if (ni == len_s) begin
                        pend_next    = cfg.base_offset + pos_reg + kmp_pkg::POS_W'(1)
                                       - kmp_pkg::POS_W'(len_reg);
                        matched_next = fail_end_reg;
                        state_next   = S_OUT;
                    end else begin
                        matched_next = ni;
                        state_next   = S_IDLE;
                    end
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = pend_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            ready_reg    <= 1'b0;
            matched_reg  <= '0;
            pos_reg      <= '0;
            m_valid_reg  <= 1'b0;
            len_reg      <= AW'(1);
            fail_end_reg <= '0;
        end else begin
            state_reg    <= state_next;
            ready_reg    <= ready_next;
            matched_reg  <= matched_next;
            pos_reg      <= pos_next;
            m_valid_reg  <= m_valid_next;
            len_reg      <= len_next;
            fail_end_reg <= fail_end_next;
        end
        k_reg      <= k_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        c_reg      <= c_next;
        pend_reg   <= pend_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (pat_we) begin
            pat_mem[pat_waddr] <= pat_wdata;
        end
        pat_qa <= pat_mem[pat_raddr_a];
        pat_qb <= pat_mem[pat_raddr_b];
    end

    always_ff @(posedge aclk) begin
        if (ft_we) begin
            ft_mem[ft_waddr] <= ft_wdata;
        end
        ft_q <= ft_mem[ft_raddr];
    end

    a_matched_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ready_reg |-> (matched_reg >= 0) && (matched_reg < len_s))
        else $error("matched count outside pattern");

    a_fail_end_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ready_reg |-> (fail_end_reg >= 0) && (fail_end_reg < len_s))
        else $error("final failure link outside pattern");

    a_build_j_behind_i: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_BRD || state_reg == S_BCMP || state_reg == S_BLINK ||
         state_reg == S_BCMP2 || state_reg == S_BFT) |-> (j_reg < i_reg) && (i_reg < len_s))
        else $error("build indices out of order");

    a_search_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCMP) |-> (i_reg >= 0) && (i_reg < len_s) && ready_reg)
        else $error("search index outside pattern");

endmodule

### rtl/core/kmp_stream_pattern_search_unit.sv
// ----------------------------------------------------------------------------
// kmp_stream_pattern_search_unit
// Streaming exact-pattern search with an optimized failure table.
//
//   channel  dir  handshake            payload
//   cfg      in   cfg_valid/cfg_ready  cfg_index[2:0], cfg_data[63:0]
//   s        in   s_valid/s_ready      s_op[1:0], s_data_byte[7:0]
//   m        out  m_valid/m_ready      m_match_position[31:0]
//
// A data word steps through the compare loop, following failure links (one
// failure memory read each); a match also loads the output register. A build
// word is accepted, copies len pattern bytes, then compares each pattern byte
// and follows failure links, paced by the registered read of the pattern
// memory.
// Op 1 and ignored words are handled in the idle state.
// Reset is synchronous and holds both ready outputs low; no clearing pass,
// the table is written before use.
// s_ready holds low while a word is at work or a match waits for the output
// register; a pending result in m does not block the next input word.
// ----------------------------------------------------------------------------
module kmp_stream_pattern_search_unit #(
    parameter int MAX_PATTERN = kmp_pkg::MAX_PATTERN_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [kmp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [kmp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [kmp_pkg::OP_W-1:0]          s_op,
    input  logic [kmp_pkg::BYTE_W-1:0]        s_data_byte,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [kmp_pkg::POS_W-1:0]         m_match_position
);

    kmp_pkg::cfg_t cfg;

    kmp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_out   (cfg)
    );

    kmp_engine #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_engine (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_data_byte      (s_data_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_match_position (m_match_position)
    );

endmodule

### tb/sv/kmp_stream_pattern_search_unit_tb.sv
// ----------------------------------------------------------------------------
// kmp_stream_pattern_search_unit_tb
// Self-checking bench for the streaming KMP pattern search unit. A directed
// table covers reset behavior, length clamping, limit, wrap and overlap; then
// random phases reprogram the pattern and stream bytes from a small alphabet
// with embedded copies of the pattern. Every word is predicted by a local
// KMP model and match positions are scored in order against the m channel.
// ----------------------------------------------------------------------------
module kmp_stream_pattern_search_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [kmp_pkg::OP_W-1:0]      OP_UNUSED     = 2'd3;
    localparam logic [kmp_pkg::CFG_IDX_W-1:0] REG_UNMAPPED  = 3'd7;
    localparam int                            SETTLE_CYCLES = 1000;
    localparam int                            RUN_LIMIT     = 2_000_000;
    localparam int                            N_PHASES      = 10;
    localparam int                            PHASE_WORDS   = 48;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_QUIET,
        ROW_HIT,
        ROW_PREDICT
    } row_kind_t;

    typedef struct packed {
        row_kind_t                         kind;
        logic [kmp_pkg::CFG_IDX_W-1:0]     code;
        logic [kmp_pkg::CFG_DATA_W-1:0]    value;
        logic [kmp_pkg::POS_W-1:0]         hit_pos;
    } stim_row_t;

    localparam int N_DIRECTED = 33;
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{ROW_QUIET,   3'(kmp_pkg::OP_DATA),    64'h41, 32'h0},
        '{ROW_QUIET,   3'(OP_UNUSED),           64'hFF, 32'h0},
        '{ROW_QUIET,   3'(kmp_pkg::OP_BUILD),   64'h00, 32'h0},
        '{ROW_HIT,     3'(kmp_pkg::OP_DATA),    64'h00, 32'h0},
        '{ROW_HIT,     3'(kmp_pkg::OP_DATA),    64'h00, 32'h1},
        '{ROW_QUIET,   3'(kmp_pkg::OP_DATA),    64'hFF, 32'h0},
        '{ROW_QUIET,   3'(kmp_pkg::OP_RESTART), 64'h5A, 32'h0},
        '{ROW_HIT,     3'(kmp_pkg::OP_DATA),    64'h00, 32'h0},
        '{ROW_CFG,     kmp_pkg::REG_PATTERN_LEN,  64'h0,  32'h0},
        '{ROW_CFG,     kmp_pkg::REG_PATTERN_W0,   64'hFF, 32'h0},
        '{ROW_HIT,     3'(kmp_pkg::OP_DATA),    64'h00, 32'h1},
        '{ROW_QUIET,   3'(kmp_pkg::OP_BUILD),   64'h00, 32'h0},
        '{ROW_HIT,     3'(kmp_pkg::OP_DATA),    64'hFF, 32'h0},
        '{ROW_CFG,     kmp_pkg::REG_BASE_OFFSET,  64'hFFFF_FFFF, 32'h0},
        '{ROW_CFG,     kmp_pkg::REG_SEARCH_LIMIT, 64'h2,         32'h0},
        '{ROW_HIT,     3'(kmp_pkg::OP_DATA),    64'hFF, 32'h0},
        '{ROW_QUIET,   3'(kmp_pkg::OP_DATA),    64'hFF, 32'h0},
        '{ROW_QUIET,   3'(kmp_pkg::OP_RESTART), 64'h00, 32'h0},
        '{ROW_HIT,     3'(kmp_pkg::OP_DATA),    64'hFF, 32'hFFFF_FFFF},
        '{ROW_CFG,     kmp_pkg::REG_BASE_OFFSET,  64'h0,         32'h0},
        '{ROW_CFG,     kmp_pkg::REG_SEARCH_LIMIT, 64'hFFFF_FFFF, 32'h0},
        '{ROW_CFG,     kmp_pkg::REG_PATTERN_LEN,  64'h2,         32'h0},
        '{ROW_CFG,     kmp_pkg::REG_PATTERN_W0,   64'hFFFF_FFFF_FFFF_0000, 32'h0},
        '{ROW_CFG,     REG_UNMAPPED,              64'hFFFF_FFFF_FFFF_FFFF, 32'h0},
        '{ROW_QUIET,   3'(kmp_pkg::OP_BUILD),   64'h00, 32'h0},
        '{ROW_QUIET,   3'(kmp_pkg::OP_DATA),    64'h00, 32'h0},
        '{ROW_HIT,     3'(kmp_pkg::OP_DATA),    64'h00, 32'h0},
        '{ROW_HIT,     3'(kmp_pkg::OP_DATA),    64'h00, 32'h1},
        '{ROW_QUIET,   3'(kmp_pkg::OP_DATA),    64'hFF, 32'h0},
        '{ROW_QUIET,   3'(kmp_pkg::OP_DATA),    64'h00, 32'h0},
        '{ROW_HIT,     3'(kmp_pkg::OP_DATA),    64'h00, 32'h4},
        '{ROW_PREDICT, 3'(kmp_pkg::OP_DATA),    64'h00, 32'h0},
        '{ROW_PREDICT, 3'(kmp_pkg::OP_DATA),    64'h80, 32'h0}
    };

    logic                             aclk;
    logic                             aresetn;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [kmp_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [kmp_pkg::CFG_DATA_W-1:0]   cfg_data;
    logic                             s_valid;
    logic                             s_ready;
    logic [kmp_pkg::OP_W-1:0]         s_op;
    logic [kmp_pkg::BYTE_W-1:0]       s_data_byte;
    logic                             m_valid;
    logic                             m_ready = 1'b0;
    logic [kmp_pkg::POS_W-1:0]        m_match_position;

    logic [kmp_pkg::POS_W-1:0]        match_pos_q [$];
    int                               mismatch_count = 0;
    int                               cycle_count = 0;
    int                               stall_left = 0;
    bit                               no_idle = 1'b0;

    // search model state
    logic [kmp_pkg::LEN_W-1:0]        reg_len;
    logic [kmp_pkg::CFG_DATA_W-1:0]   reg_words [kmp_pkg::PAT_WORDS];
    logic [kmp_pkg::POS_W-1:0]        reg_base;
    logic [kmp_pkg::POS_W-1:0]        reg_limit;
    logic [kmp_pkg::BYTE_W-1:0]       key_bytes [kmp_pkg::MAX_PATTERN_DEF+1];
    int                               key_len;
    int                               fail_link [kmp_pkg::MAX_PATTERN_DEF+1];
    bit                               links_built;
    int                               matched_len;
    logic [kmp_pkg::POS_W-1:0]        stream_pos;

    kmp_stream_pattern_search_unit u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_data_byte      (s_data_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_match_position (m_match_position)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    function automatic void build_fail_links();
        int n;
        int i;
        int j;
        n = int'(reg_len);
        if (n < 1) n = 1;
        if (n > kmp_pkg::MAX_PATTERN_DEF) n = kmp_pkg::MAX_PATTERN_DEF;
        key_len = n;
        for (i = 0; i <= kmp_pkg::MAX_PATTERN_DEF; i++) begin
            key_bytes[i] = (i < n) ? reg_words[i / 8][(i % 8) * 8 +: 8] : 8'h00;
        end
        fail_link[0] = -1;
        i = 0;
        j = -1;
        while (i < n) begin
            while (j > -1 && key_bytes[i] != key_bytes[j]) j = fail_link[j];
            i++;
            j++;
            if (i < n && key_bytes[i] == key_bytes[j]) fail_link[i] = fail_link[j];
            else fail_link[i] = j;
        end
    endfunction

    function automatic bit predict_match(input logic [kmp_pkg::OP_W-1:0] op,
                                         input logic [kmp_pkg::BYTE_W-1:0] b,
                                         output logic [kmp_pkg::POS_W-1:0] pos);
        int k;
        pos = '0;
        case (op)
            kmp_pkg::OP_BUILD: begin
                build_fail_links();
                links_built = 1'b1;
                matched_len = 0;
                stream_pos  = '0;
                return 1'b0;
            end
            kmp_pkg::OP_RESTART: begin
                matched_len = 0;
                stream_pos  = '0;
                return 1'b0;
            end
            kmp_pkg::OP_DATA: begin
                if (!links_built || stream_pos >= reg_limit) return 1'b0;
                k = matched_len;
                while (k > -1 && key_bytes[k] != b) k = fail_link[k];
                k++;
                stream_pos++;
                if (k >= key_len) begin
                    pos = reg_base + stream_pos - 32'(key_len);
                    matched_len = fail_link[key_len];
                    return 1'b1;
                end
                matched_len = k;
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic send_word(input logic [kmp_pkg::OP_W-1:0] op,
                             input logic [kmp_pkg::BYTE_W-1:0] b,
                             input row_kind_t mode,
                             input logic [kmp_pkg::POS_W-1:0] typed_pos);
        int gap;
        bit hit;
        logic [kmp_pkg::POS_W-1:0] pos;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_op        <= op;
        s_data_byte <= b;
        s_valid     <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        hit = predict_match(op, b, pos);
        case (mode)
            ROW_HIT:     match_pos_q.push_back(typed_pos);
            ROW_PREDICT: if (hit) match_pos_q.push_back(pos);
            default: ;
        endcase
    endtask

    task automatic write_reg(input logic [kmp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [kmp_pkg::CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            kmp_pkg::REG_PATTERN_LEN:  reg_len      = val[kmp_pkg::LEN_W-1:0];
            kmp_pkg::REG_PATTERN_W0:   reg_words[0] = val;
            kmp_pkg::REG_PATTERN_W1:   reg_words[1] = val;
            kmp_pkg::REG_PATTERN_W2:   reg_words[2] = val;
            kmp_pkg::REG_PATTERN_W3:   reg_words[3] = val;
            kmp_pkg::REG_BASE_OFFSET:  reg_base     = val[kmp_pkg::POS_W-1:0];
            kmp_pkg::REG_SEARCH_LIMIT: reg_limit    = val[kmp_pkg::POS_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // hold the sender until every match position is in, then let the core settle
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (match_pos_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin : result_check
        logic [kmp_pkg::POS_W-1:0] want;
        int stall;
        if (aresetn && m_valid && m_ready) begin
            if (match_pos_q.size() == 0) begin
                $display("%0t: match_position expected none actual %08h", $time,
                         m_match_position);
                mismatch_count++;
            end else begin
                want = match_pos_q.pop_front();
                if (m_match_position !== want) begin
                    $display("%0t: match_position expected %08h actual %08h", $time,
                             want, m_match_position);
                    mismatch_count++;
                end
            end
        end
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else begin
            stall = pick_gap();
            m_ready    <= (stall == 0);
            stall_left <= stall;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("%0t: timeout, %0d match positions outstanding", $time,
                     match_pos_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : stimulus
        int ph;
        int n;
        int r;
        int k;
        int eff;
        int budget;
        logic [kmp_pkg::BYTE_W-1:0]     sym [2];
        logic [kmp_pkg::BYTE_W-1:0]     pbytes [kmp_pkg::MAX_PATTERN_DEF];
        logic [kmp_pkg::CFG_DATA_W-1:0] words [kmp_pkg::PAT_WORDS];
        logic [kmp_pkg::LEN_W-1:0]      len_cfg;
        logic [kmp_pkg::POS_W-1:0]      base_cfg;
        logic [kmp_pkg::POS_W-1:0]      limit_cfg;

        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_op        = kmp_pkg::OP_BUILD;
        s_data_byte = '0;
        cfg_valid   = 1'b0;
        cfg_index   = kmp_pkg::REG_PATTERN_LEN;
        cfg_data    = '0;
        reg_len     = 6'd1;
        for (k = 0; k < kmp_pkg::PAT_WORDS; k++) reg_words[k] = '0;
        reg_base    = '0;
        reg_limit   = 32'hFFFF_FFFF;
        links_built = 1'b0;
        matched_len = 0;
        stream_pos  = '0;
        key_len     = 1;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        for (n = 0; n < N_DIRECTED; n++) begin
            if (DIRECTED[n].kind == ROW_CFG) begin
                wait_drained();
                write_reg(DIRECTED[n].code, DIRECTED[n].value);
            end else begin
                send_word(DIRECTED[n].code[kmp_pkg::OP_W-1:0],
                          DIRECTED[n].value[kmp_pkg::BYTE_W-1:0],
                          DIRECTED[n].kind, DIRECTED[n].hit_pos);
            end
        end

        for (ph = 0; ph < N_PHASES; ph++) begin
            sym[0] = 8'($urandom);
            sym[1] = 8'($urandom);
            if (ph == 0) begin
                len_cfg = 6'h3F;
                sym[0]  = 8'h61;
                sym[1]  = 8'h61;
            end else if (ph == 1) begin
                len_cfg = 6'd0;
            end else if (ph == 2) begin
                len_cfg = 6'd32;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60)      len_cfg = 6'($urandom_range(1, 4));
                else if (r < 85) len_cfg = 6'($urandom_range(5, 10));
                else if (r < 95) len_cfg = 6'd32;
                else             len_cfg = 6'($urandom_range(33, 63));
            end
            eff = (len_cfg == 6'd0) ? 1 : (len_cfg > 6'd32) ? 32 : int'(len_cfg);
            for (k = 0; k < kmp_pkg::MAX_PATTERN_DEF; k++) begin
                pbytes[k] = (k < eff) ? sym[$urandom_range(0, 1)] : 8'($urandom);
                words[k / 8][(k % 8) * 8 +: 8] = pbytes[k];
            end
            if (ph % 3 == 0)  base_cfg = 32'hFFFF_FFFF - 32'($urandom_range(0, 20));
            else if (ph == 1) base_cfg = '0;
            else              base_cfg = $urandom;
            if (ph == N_PHASES - 1) limit_cfg = '0;
            else if (ph % 4 == 1)   limit_cfg = 32'($urandom_range(8, 40));
            else                    limit_cfg = 32'hFFFF_FFFF;

            wait_drained();
            no_idle = (ph % 4 == 2);
            write_reg(kmp_pkg::REG_PATTERN_W0, words[0]);
            write_reg(kmp_pkg::REG_PATTERN_W1, words[1]);
            write_reg(kmp_pkg::REG_PATTERN_W2, words[2]);
            write_reg(kmp_pkg::REG_PATTERN_W3, words[3]);
            write_reg(kmp_pkg::REG_PATTERN_LEN, {$urandom, 26'($urandom), len_cfg});
            write_reg(kmp_pkg::REG_BASE_OFFSET, {$urandom, base_cfg});
            write_reg(kmp_pkg::REG_SEARCH_LIMIT, {$urandom, limit_cfg});
            if (ph % 3 == 1) write_reg(REG_UNMAPPED, {$urandom, $urandom});
            send_word(kmp_pkg::OP_BUILD, 8'($urandom), ROW_PREDICT, '0);

            budget = (limit_cfg == '0) ? 12 : PHASE_WORDS;
            n = 0;
            while (n < budget) begin
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    for (k = 0; k < eff; k++) begin
                        send_word(kmp_pkg::OP_DATA, pbytes[k], ROW_PREDICT, '0);
                    end
                    n += eff;
                end else begin
                    if (r < 80)      send_word(kmp_pkg::OP_DATA, sym[$urandom_range(0, 1)],
                                               ROW_PREDICT, '0);
                    else if (r < 88) send_word(kmp_pkg::OP_DATA, 8'($urandom),
                                               ROW_PREDICT, '0);
                    else if (r < 93) send_word(kmp_pkg::OP_RESTART, 8'($urandom),
                                               ROW_PREDICT, '0);
                    else if (r < 96) send_word(OP_UNUSED, 8'($urandom), ROW_PREDICT, '0);
                    else             send_word(kmp_pkg::OP_BUILD, 8'($urandom),
                                               ROW_PREDICT, '0);
                    n++;
                end
            end
        end

        no_idle = 1'b0;
        wait_drained();
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
